[hw/rtl/sia_pkg.sv]
package sia_pkg;

    // Table geometry and handle width.
    localparam int SLOTS        = 256;
    localparam int HANDLE_WIDTH = 16;

    // Fixed widths of the port fields.
    localparam int IDX_W  = 8;
    localparam int HIN_W  = 16;
    localparam int KIND_W = 3;

    // Slot address and length widths; the length can hold SLOTS itself.
    localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int LEN_W  = $clog2(SLOTS + 1);
    localparam int CMP_W  = ((LEN_W > IDX_W) ? LEN_W : IDX_W) + 1;

    // Two-level priority search: groups of GRP bits.
    localparam int GRP   = 16;
    localparam int LW    = $clog2(GRP);
    localparam int NGRP  = (SLOTS + GRP - 1) / GRP;
    localparam int GW    = (NGRP > 1) ? $clog2(NGRP) : 1;
    localparam int PK_W  = GW + LW;
    localparam int PAD_N = NGRP * GRP;

    typedef enum logic [KIND_W-1:0] {
        K_ALLOC_LOW = 3'd0,
        K_ALLOC_AT  = 3'd1,
        K_DELETE    = 3'd2,
        K_EXISTS    = 3'd3,
        K_CLEAR     = 3'd4
    } t_kind;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_OVERWRITE = 2'd1,
        ST_NOT_FOUND = 2'd2,
        ST_FULL      = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_GROUP,
        S_PICK,
        S_FIN
    } t_state;

    typedef struct packed {
        logic latch;
        logic rd;
        logic grp;
        logic pick;
        logic fin;
    } t_cmd;

    typedef struct packed {
        t_kind kind;
    } t_stat;

endpackage

[hw/rtl/sia_ctrl.sv]
module sia_ctrl (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      start,
    input  logic [sia_pkg::KIND_W-1:0] i_kind,
    input  sia_pkg::t_stat            i_stat,
    output sia_pkg::t_cmd             o_cmd,
    output logic                      busy
);
    import sia_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    case (t_kind'(i_kind))
                        K_ALLOC_LOW: n_state = S_GROUP;
                        K_ALLOC_AT:  n_state = S_READ;
                        K_DELETE:    n_state = S_READ;
                        default:     n_state = S_FIN;
                    endcase
                end
            end
            S_READ: begin
                // A delete goes on to find the new highest occupied slot.
                n_state = (i_stat.kind == K_DELETE) ? S_GROUP : S_FIN;
            end
            S_GROUP: n_state = S_PICK;
            S_PICK:  n_state = S_FIN;
            S_FIN:   n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd       = '0;
        busy        = 1'b1;
        case (r_state)
            S_IDLE: begin
                busy        = 1'b0;
                o_cmd.latch = start;
            end
            S_READ:  o_cmd.rd   = 1'b1;
            S_GROUP: o_cmd.grp  = 1'b1;
            S_PICK:  o_cmd.pick = 1'b1;
            S_FIN:   o_cmd.fin  = 1'b1;
            default: busy = 1'b1;
        endcase
    end

endmodule

[hw/rtl/sia_datapath.sv]
module sia_datapath (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  sia_pkg::t_cmd              i_cmd,
    input  logic [sia_pkg::KIND_W-1:0] i_kind,
    input  logic [sia_pkg::IDX_W-1:0]  i_slot_index,
    input  logic [sia_pkg::HIN_W-1:0]  i_new_handle,
    output sia_pkg::t_stat             o_stat,
    output logic [sia_pkg::IDX_W-1:0]  o_result_index,
    output logic [1:0]                 o_status,
    output logic                       o_present,
    output logic [sia_pkg::HIN_W-1:0]  o_released_handle,
    output logic                       o_released_valid,
    output logic                       o_done
);
    import sia_pkg::*;

    function automatic logic [LW-1:0] first_lo(input logic [GRP-1:0] v);
        logic [LW-1:0] r;
        r = '0;
        for (int k = GRP - 1; k >= 0; k--) begin
            if (v[k]) r = LW'(k);
        end
        return r;
    endfunction

    function automatic logic [GW-1:0] first_grp(input logic [NGRP-1:0] v);
        logic [GW-1:0] r;
        r = '0;
        for (int k = NGRP - 1; k >= 0; k--) begin
            if (v[k]) r = GW'(k);
        end
        return r;
    endfunction

    // Item registers.
    t_kind                r_kind;
    logic [IDX_W-1:0]     r_idx;
    logic [HANDLE_WIDTH-1:0] r_handle;

    // Table state.
    logic [SLOTS-1:0]     r_valid;
    logic [SLOTS-1:0]     n_valid;
    logic [LEN_W-1:0]     r_len;
    logic [LEN_W-1:0]     n_len;
    logic [LEN_W-1:0]     r_hint;
    logic [LEN_W-1:0]     n_hint;
    logic [HANDLE_WIDTH-1:0] mem [SLOTS];

    // Working registers.
    logic [HANDLE_WIDTH-1:0] r_rd;
    logic                 r_hit;
    logic [NGRP-1:0]      r_grp;
    logic [PK_W-1:0]      r_pick;
    logic                 r_found;

    // Result registers.
    logic [IDX_W-1:0]     r_o_idx;
    t_status              r_o_st;
    logic                 r_o_pres;
    logic [HIN_W-1:0]     r_o_rel;
    logic                 r_o_relv;
    logic                 r_done;

    logic [IDX_W-1:0]     n_o_idx;
    t_status              n_o_st;
    logic                 n_o_pres;
    logic [HIN_W-1:0]     n_o_rel;
    logic                 n_o_relv;

    logic                 we;
    logic [SLOT_W-1:0]    wa;
    logic [SLOT_W-1:0]    slot_a;
    logic [SLOT_W-1:0]    pick_slot;
    logic [LEN_W-1:0]     pick_len;
    logic [LEN_W-1:0]     hc;
    logic                 in_rng;
    logic                 below_len;
    logic                 hit_now;
    logic                 rev;
    logic [PAD_N-1:0]     vec;
    logic [NGRP-1:0]      grp_any;
    logic [GW-1:0]        gsel;
    logic [LW-1:0]        lsel;

    assign slot_a    = SLOT_W'(r_idx);
    assign pick_slot = SLOT_W'(r_pick);
    assign pick_len  = LEN_W'(r_pick);
    assign in_rng    = CMP_W'(r_idx) < CMP_W'(SLOTS);
    assign below_len = CMP_W'(r_idx) < CMP_W'(r_len);
    assign hit_now   = in_rng && below_len && r_valid[slot_a];
    assign hc        = (r_hint > r_len) ? r_len : r_hint;
    assign rev       = (r_kind == K_DELETE);

    // Free search: first empty slot at or above the clamped hint. Slots past the
    // length are always empty, so a hit at the length itself is an append.
    // Delete search runs on the reversed bitmap to find the highest occupied slot.
    always_comb begin
        vec = '0;
        for (int i = 0; i < SLOTS; i++) begin
            if (rev) begin
                vec[i] = r_valid[SLOTS-1-i];
            end else begin
                vec[i] = !r_valid[i] && (LEN_W'(i) >= hc);
            end
        end
    end

    always_comb begin
        for (int g = 0; g < NGRP; g++) begin
            grp_any[g] = |vec[g*GRP +: GRP];
        end
    end

    assign gsel = first_grp(r_grp);
    assign lsel = first_lo(vec[gsel*GRP +: GRP]);

    always_comb begin
        n_valid  = r_valid;
        n_len    = r_len;
        n_hint   = r_hint;
        we       = 1'b0;
        wa       = slot_a;
        n_o_idx  = '0;
        n_o_st   = ST_OK;
        n_o_pres = 1'b0;
        n_o_rel  = '0;
        n_o_relv = 1'b0;
        if (i_cmd.rd && rev && hit_now) begin
            n_valid[slot_a] = 1'b0;
        end
        if (i_cmd.fin) begin
            case (r_kind)
                K_ALLOC_LOW: begin
                    if (r_found) begin
                        we                 = 1'b1;
                        wa                 = pick_slot;
                        n_valid[pick_slot] = 1'b1;
                        if (pick_len == r_len) begin
                            n_len = r_len + 1'b1;
                        end
                        n_hint  = pick_len + 1'b1;
                        n_o_idx = IDX_W'(r_pick);
                    end else begin
                        n_o_st = ST_FULL;
                    end
                end
                K_ALLOC_AT: begin
                    n_o_idx = r_idx;
                    if (!in_rng) begin
                        n_o_st = ST_FULL;
                    end else begin
                        if (r_hit) begin
                            n_o_rel  = HIN_W'(r_rd);
                            n_o_relv = 1'b1;
                            n_o_st   = ST_OVERWRITE;
                        end
                        if (!below_len) begin
                            n_len = LEN_W'(r_idx) + 1'b1;
                        end
                        we              = 1'b1;
                        n_valid[slot_a] = 1'b1;
                    end
                end
                K_DELETE: begin
                    n_o_idx = r_idx;
                    if (!r_hit) begin
                        n_o_st = ST_NOT_FOUND;
                    end else begin
                        n_o_rel  = HIN_W'(r_rd);
                        n_o_relv = 1'b1;
                        // Length becomes one past the highest remaining slot.
                        n_len = r_found ? (LEN_W'(SLOTS) - pick_len) : '0;
                        if (CMP_W'(r_idx) < CMP_W'(r_hint)) begin
                            n_hint = LEN_W'(r_idx);
                        end
                    end
                end
                K_EXISTS: begin
                    n_o_idx = r_idx;
                    if (hit_now) begin
                        n_o_pres = 1'b1;
                    end else begin
                        n_o_st = ST_NOT_FOUND;
                    end
                end
                K_CLEAR: begin
                    n_valid = '0;
                    n_len   = '0;
                    n_hint  = '0;
                end
                default: n_o_st = ST_FULL;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_len   <= '0;
            r_hint  <= '0;
            r_done  <= 1'b0;
        end else begin
            r_valid <= n_valid;
            r_len   <= n_len;
            r_hint  <= n_hint;
            r_done  <= i_cmd.fin;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_kind   <= t_kind'(i_kind);
            r_idx    <= i_slot_index;
            r_handle <= HANDLE_WIDTH'(i_new_handle);
        end
        if (i_cmd.rd) begin
            r_hit <= hit_now;
        end
        if (i_cmd.grp) begin
            r_grp <= grp_any;
        end
        if (i_cmd.pick) begin
            r_pick  <= {gsel, lsel};
            r_found <= |r_grp;
        end
        if (i_cmd.fin) begin
            r_o_idx  <= n_o_idx;
            r_o_st   <= n_o_st;
            r_o_pres <= n_o_pres;
            r_o_rel  <= n_o_rel;
            r_o_relv <= n_o_relv;
        end
    end

    // Handle memory: one write and one registered read.
    always_ff @(posedge i_clk) begin
        if (we) begin
            mem[wa] <= r_handle;
        end
        if (i_cmd.rd) begin
            r_rd <= mem[slot_a];
        end
    end

    assign o_stat.kind       = r_kind;
    assign o_result_index    = r_o_idx;
    assign o_status          = r_o_st;
    assign o_present         = r_o_pres;
    assign o_released_handle = r_o_rel;
    assign o_released_valid  = r_o_relv;
    assign o_done            = r_done;

endmodule

[hw/rtl/slot_index_allocator_unit.sv]
// Channel  | Handshake              | Words
// ---------+------------------------+----------------------------------------------
// command  | start, busy            | i_kind, i_slot_index, i_new_handle
// result   | o_done (one cycle)     | o_result_index, o_status, o_present,
//          |                        | o_released_handle, o_released_valid
//
// A command word is taken when start is high and busy is low; one result word
// follows with o_done high for a single cycle, and the receiver cannot stall it.
// Allocate-lowest runs a two-stage priority search over the valid bitmap (group,
// then pick) before its result; allocate-at first reads the handle memory, delete
// reads it and then runs the search for the new length, the others go to the result.
// busy drops in the cycle the result is shown, so a new word may enter then.
// Synchronous reset empties the table at once; no clearing pass is needed.
module slot_index_allocator_unit (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       start,
    output logic                       busy,
    input  logic [sia_pkg::KIND_W-1:0] i_kind,
    input  logic [sia_pkg::IDX_W-1:0]  i_slot_index,
    input  logic [sia_pkg::HIN_W-1:0]  i_new_handle,
    output logic                       o_done,
    output logic [sia_pkg::IDX_W-1:0]  o_result_index,
    output logic [1:0]                 o_status,
    output logic                       o_present,
    output logic [sia_pkg::HIN_W-1:0]  o_released_handle,
    output logic                       o_released_valid
);
    import sia_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    sia_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .i_kind  (i_kind),
        .i_stat  (stat),
        .o_cmd   (cmd),
        .busy    (busy)
    );

    sia_datapath u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (cmd),
        .i_kind            (i_kind),
        .i_slot_index      (i_slot_index),
        .i_new_handle      (i_new_handle),
        .o_stat            (stat),
        .o_result_index    (o_result_index),
        .o_status          (o_status),
        .o_present         (o_present),
        .o_released_handle (o_released_handle),
        .o_released_valid  (o_released_valid),
        .o_done            (o_done)
    );

endmodule
